>>> rtl/phr_pkg.sv
package phr_pkg;

	// Channel and register widths
	localparam int CH_W  = 8;
	localparam int HUE_W = 15;
	localparam int SUM_W = 9;

	// Default number of fraction bits of the fixed-point datapath
	localparam int FRAC_BITS_DEF = 16;

	// Full turn in 1/64 degree
	localparam logic [HUE_W-1:0] HUE_FULL = 15'd23040;

	// Lightness divisor: sum of max and min over 2 * 255
	localparam logic [SUM_W-1:0] LIGHT_DIV = 9'd510;

	localparam logic [SUM_W-1:0] SUM_HALF = 9'd255;

	localparam logic [CH_W-1:0] CH_MAX = 8'd255;

endpackage

>>> rtl/phr_pix_in_if.sv
interface phr_pix_in_if;
	logic                      valid;
	logic                      ready;
	logic [phr_pkg::CH_W-1:0]  red_in;
	logic [phr_pkg::CH_W-1:0]  green_in;
	logic [phr_pkg::CH_W-1:0]  blue_in;
	logic [phr_pkg::CH_W-1:0]  alpha_in;

	modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
	modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

>>> rtl/phr_pix_out_if.sv
interface phr_pix_out_if;
	logic                      valid;
	logic                      ready;
	logic [phr_pkg::CH_W-1:0]  red_out;
	logic [phr_pkg::CH_W-1:0]  green_out;
	logic [phr_pkg::CH_W-1:0]  blue_out;
	logic [phr_pkg::CH_W-1:0]  alpha_out;

	modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
	modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

>>> rtl/phr_div.sv
// Pipelined restoring divider, one quotient bit per stage, MSB first.
module phr_div #(
	parameter int DW = 25,
	parameter int VW = 9
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] num,
	input  logic [VW-1:0] den,
	output logic [DW-1:0] quo
);

	logic [VW-1:0] rem_s [DW+1];
	logic [DW-1:0] num_s [DW+1];
	logic [DW-1:0] quo_s [DW+1];
	logic [VW-1:0] den_s [DW+1];

	assign rem_s[0] = '0;
	assign num_s[0] = num;
	assign quo_s[0] = '0;
	assign den_s[0] = den;

	for (genvar i = 0; i < DW; i++) begin : g_stage
		logic [VW:0] trial;
		logic        fits;

		always_comb begin
			trial = {rem_s[i], num_s[i][DW-1-i]};
			fits  = (trial >= {1'b0, den_s[i]});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= fits ? VW'(trial - {1'b0, den_s[i]}) : VW'(trial);
				quo_s[i+1] <= {quo_s[i][DW-2:0], fits};
				num_s[i+1] <= num_s[i];
				den_s[i+1] <= den_s[i];
			end
		end
	end

	assign quo = quo_s[DW];

endmodule

>>> rtl/phr_chan.sv
// Back conversion of one channel: region select, ramp multiply, offset, byte scale.
module phr_chan #(
	parameter int FRAC_BITS = phr_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [FRAC_BITS:0]             t,
	input  logic signed [FRAC_BITS+2:0]    p,
	input  logic [FRAC_BITS+1:0]           q,
	output logic [phr_pkg::CH_W-1:0]       byte_s4
);

	localparam int F = FRAC_BITS;
	localparam logic [F+3:0] ONE        = (F+4)'(1) << F;
	localparam logic [F+3:0] TWO_THIRDS = ((F+4)'(2) << F) / 3;

	typedef enum logic [1:0] {MODE_RAMP, MODE_Q, MODE_P} chan_mode_t;

	logic [F+3:0]         t_w, t6, t2, t3, w, m;
	logic signed [F+3:0]  dq;
	logic [F+2:0]         d;
	chan_mode_t           mode;

	always_comb begin
		t_w = (F+4)'(t);
		t6  = t_w * (F+4)'(6);
		t2  = t_w << 1;
		t3  = t_w * (F+4)'(3);
		w   = (t_w <= TWO_THIRDS) ? (TWO_THIRDS - t_w) : '0;
		dq  = $signed({2'b00, q}) - (F+4)'(p);
		d   = dq[F+3] ? '0 : dq[F+2:0];
		if (t6 < ONE) begin
			mode = MODE_RAMP;
			m    = t6;
		end else if (t2 < ONE) begin
			mode = MODE_Q;
			m    = '0;
		end else if (t3 < (ONE << 1)) begin
			mode = MODE_RAMP;
			m    = w * (F+4)'(6);
		end else begin
			mode = MODE_P;
			m    = '0;
		end
	end

	chan_mode_t                mode_s1, mode_s2;
	logic [F+3:0]              m_s1;
	logic [F+2:0]              d_s1;
	logic signed [F+2:0]       p_s1, p_s2;
	logic [F+1:0]              q_s1, q_s2;
	logic [F+2:0]              ramp_s2;
	logic [2*F+6:0]            prod;
	logic signed [F+3:0]       v_s3;
	logic signed [F+11:0]      scaled;
	logic [11:0]               hi;
	logic [phr_pkg::CH_W-1:0]  byte_c;

	always_comb begin
		prod   = (2*F+7)'(d_s1) * (2*F+7)'(m_s1);
		scaled = ($signed((F+12)'(v_s3)) <<< 8) - (F+12)'(v_s3);
		hi     = scaled[F+11:F];
		if (scaled < 0) begin
			byte_c = '0;
		end else if (hi > 12'(phr_pkg::CH_MAX)) begin
			byte_c = phr_pkg::CH_MAX;
		end else begin
			byte_c = hi[phr_pkg::CH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			m_s1    <= m;
			d_s1    <= d;
			p_s1    <= p;
			q_s1    <= q;

			mode_s2 <= mode_s1;
			ramp_s2 <= prod[2*F+2:F];
			p_s2    <= p_s1;
			q_s2    <= q_s1;

			case (mode_s2)
				MODE_RAMP: v_s3 <= (F+4)'(p_s2) + $signed({1'b0, ramp_s2});
				MODE_Q:    v_s3 <= $signed({2'b00, q_s2});
				default:   v_s3 <= (F+4)'(p_s2);
			endcase

			byte_s4 <= byte_c;
		end
	end

endmodule

>>> rtl/pixel_hue_replace_unit.sv
// Throughput: one pixel per cycle while the output is not stalled; the saturation
// divider is fully pipelined at one quotient bit per stage and sets the depth.
// Reset: arst_n clears all valid bits and target_hue (hue 0); datapath registers
// are not reset. A stalled output freezes the whole pipeline in place.
module pixel_hue_replace_unit #(
	parameter int FRAC_BITS = phr_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [phr_pkg::HUE_W-1:0]     cfg_data,
	phr_pix_in_if.sink                    pix_in,
	phr_pix_out_if.source                 pix_out
);

	localparam int F   = FRAC_BITS;
	localparam int CW  = phr_pkg::CH_W;
	localparam int SW  = phr_pkg::SUM_W;
	localparam int HW  = phr_pkg::HUE_W;
	// Divider width: the dividend is diff << F, sized here as the sum width plus F
	localparam int DW  = F + SW;
	// s1, divider, two HSL stages, four channel stages, output register
	localparam int LAT = DW + 8;

	localparam logic [F+1:0] ONE   = (F+2)'(1) << F;
	localparam logic [F+1:0] HALF  = (F+2)'(1) << (F - 1);
	localparam logic [F+1:0] THIRD = ((F+2)'(1) << F) / 3;

	// Reciprocals for the constant divisors, rounded up; the shifts are large enough
	// that the product floor equals the exact quotient over the whole input range
	localparam int     LIT_K  = 18;
	localparam int     HUE_K  = 21;
	localparam int     LIT_MW = F + 10;
	localparam int     HUE_MW = F + 7;
	localparam longint LIT_M  = ((longint'(1) << (F + LIT_K)) +
		longint'(phr_pkg::LIGHT_DIV) - 1) / longint'(phr_pkg::LIGHT_DIV);
	localparam longint HUE_M  = ((longint'(1) << (F + HUE_K)) +
		longint'(phr_pkg::HUE_FULL) - 1) / longint'(phr_pkg::HUE_FULL);

	// Advance the whole pipeline unless the output holds an unaccepted item
	logic en;
	assign en           = !pix_out.valid || pix_out.ready;
	assign pix_in.ready = en;

	// Configuration register
	logic [phr_pkg::HUE_W-1:0] target_hue_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_hue_q <= '0;
		end else if (cfg_we) begin
			target_hue_q <= cfg_data;
		end
	end

	// Input stage: max, min, sum, difference, saturation divisor and clamped hue
	logic [CW-1:0]             mx, mn;
	logic [SW-1:0]             sum_c;
	logic [phr_pkg::HUE_W-1:0] hue_c;

	always_comb begin
		mx = pix_in.red_in;
		mn = pix_in.red_in;
		if (pix_in.green_in > mx) mx = pix_in.green_in;
		if (pix_in.blue_in  > mx) mx = pix_in.blue_in;
		if (pix_in.green_in < mn) mn = pix_in.green_in;
		if (pix_in.blue_in  < mn) mn = pix_in.blue_in;
		sum_c = SW'(mx) + SW'(mn);
		// Clamp the hue to a full turn
		hue_c = (target_hue_q > phr_pkg::HUE_FULL) ? phr_pkg::HUE_FULL : target_hue_q;
	end

	logic [SW-1:0]             sum_s1;
	logic [CW-1:0]             diff_s1, den_s1;
	logic [phr_pkg::HUE_W-1:0] hue_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1  <= sum_c;
			diff_s1 <= mx - mn;
			den_s1  <= (sum_c <= phr_pkg::SUM_HALF) ? sum_c[CW-1:0]
			                                        : CW'(phr_pkg::LIGHT_DIV - sum_c);
			hue_s1  <= hue_c;
		end
	end

	// Sideband: valid bits, alpha, grey flag and grey value ride along the pipe
	logic          vld_s  [LAT];
	logic [CW-1:0] alpha_s[LAT-1];
	logic          grey_s [LAT-1];
	logic [CW-1:0] gval_s [LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= pix_in.valid;
			for (int i = 1; i < LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s[0] <= pix_in.alpha_in;
			grey_s[0]  <= (mx == mn);
			gval_s[0]  <= sum_c[SW-1:1];
			for (int i = 1; i < LAT-1; i++) begin
				alpha_s[i] <= alpha_s[i-1];
				grey_s[i]  <= grey_s[i-1];
				gval_s[i]  <= gval_s[i-1];
			end
		end
	end

	// Saturation quotient, DW stages deep
	logic [DW-1:0] quo_sat;

	phr_div #(.DW(DW), .VW(SW)) u_div_sat (
		.clk (clk),
		.en  (en),
		.num (DW'({diff_s1, F'(0)})),
		.den (SW'(den_s1)),
		.quo (quo_sat)
	);

	// Lightness and hue fraction by reciprocal multiply, then delayed DW stages
	// to line up with the saturation quotient
	logic [SW+LIT_MW-1:0] lit_prod;
	logic [HW+HUE_MW-1:0] hue_prod;

	always_comb begin
		lit_prod = (SW+LIT_MW)'(sum_s1) * (SW+LIT_MW)'(LIT_M);
		hue_prod = (HW+HUE_MW)'(hue_s1) * (HW+HUE_MW)'(HUE_M);
	end

	logic [F:0] lit_d [DW];
	logic [F:0] hue_d [DW];

	always_ff @(posedge clk) begin
		if (en) begin
			lit_d[0] <= lit_prod[LIT_K+F:LIT_K];
			hue_d[0] <= hue_prod[HUE_K+F:HUE_K];
			for (int i = 1; i < DW; i++) begin
				lit_d[i] <= lit_d[i-1];
				hue_d[i] <= hue_d[i-1];
			end
		end
	end

	// Stage x1: L*S product and the three hue offsets wrapped into one turn
	logic [F:0]   lf, sf;
	logic [F+1:0] hk, t_r_raw, t_r, t_b;

	always_comb begin
		lf      = lit_d[DW-1];
		sf      = quo_sat[F:0];
		hk      = (F+2)'(hue_d[DW-1]);
		t_r_raw = hk + THIRD;
		t_r     = (t_r_raw > ONE) ? (t_r_raw - ONE) : t_r_raw;
		t_b     = (hk < THIRD) ? (hk + ONE - THIRD) : (hk - THIRD);
	end

	logic [2*F+1:0] ls_prod_x1;
	logic [F:0]     lf_x1, sf_x1, tr_x1, tg_x1, tb_x1;

	always_ff @(posedge clk) begin
		if (en) begin
			ls_prod_x1 <= (2*F+2)'(lf) * (2*F+2)'(sf);
			lf_x1      <= lf;
			sf_x1      <= sf;
			tr_x1      <= t_r[F:0];
			tg_x1      <= hk[F:0];
			tb_x1      <= t_b[F:0];
		end
	end

	// Stage x2: q and p of the piecewise rule
	logic [F+1:0]        ls, lf_w, q_c;
	logic signed [F+2:0] p_c;

	always_comb begin
		ls   = ls_prod_x1[2*F+1:F];
		lf_w = (F+2)'(lf_x1);
		q_c  = (lf_w < HALF) ? (lf_w + ls) : (lf_w + (F+2)'(sf_x1) - ls);
		p_c  = $signed({lf_w, 1'b0}) - $signed({1'b0, q_c});
	end

	logic [F+1:0]        q_x2;
	logic signed [F+2:0] p_x2;
	logic [F:0]          tr_x2, tg_x2, tb_x2;

	always_ff @(posedge clk) begin
		if (en) begin
			q_x2  <= q_c;
			p_x2  <= p_c;
			tr_x2 <= tr_x1;
			tg_x2 <= tg_x1;
			tb_x2 <= tb_x1;
		end
	end

	// Per-channel back conversion, four stages each
	logic [CW-1:0] red_c, green_c, blue_c;

	phr_chan #(.FRAC_BITS(F)) u_chan_red (
		.clk (clk), .en (en), .t (tr_x2), .p (p_x2), .q (q_x2), .byte_s4 (red_c)
	);
	phr_chan #(.FRAC_BITS(F)) u_chan_green (
		.clk (clk), .en (en), .t (tg_x2), .p (p_x2), .q (q_x2), .byte_s4 (green_c)
	);
	phr_chan #(.FRAC_BITS(F)) u_chan_blue (
		.clk (clk), .en (en), .t (tb_x2), .p (p_x2), .q (q_x2), .byte_s4 (blue_c)
	);

	// Output register: grey pixels take truncated lightness on all channels
	logic grey_q;

	always_ff @(posedge clk) begin
		if (en) begin
			grey_q            <= grey_s[LAT-2];
			pix_out.alpha_out <= alpha_s[LAT-2];
			pix_out.red_out   <= grey_s[LAT-2] ? gval_s[LAT-2] : red_c;
			pix_out.green_out <= grey_s[LAT-2] ? gval_s[LAT-2] : green_c;
			pix_out.blue_out  <= grey_s[LAT-2] ? gval_s[LAT-2] : blue_c;
		end
	end

	assign pix_out.valid = vld_s[LAT-1];

	// Grey items must leave with three equal channels
	a_grey_equal: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && grey_q |->
			pix_out.red_out == pix_out.green_out && pix_out.green_out == pix_out.blue_out)
		else $error("grey item with unequal channels");

	// Hue entering the reciprocal multiply never exceeds a full turn
	a_hue_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] |-> hue_s1 <= phr_pkg::HUE_FULL)
		else $error("hue not clamped");

	// Lightness and saturation of a colored item stay within one
	a_ls_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DW+1] && !grey_s[DW+1] |-> (F+2)'(lf_x1) <= ONE && (F+2)'(sf_x1) <= ONE)
		else $error("lightness or saturation above one");

	// A stalled pipeline keeps its valid bits at index 0 and DW in place
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s[DW]) && $stable(vld_s[0]))
		else $error("valid bit moved during stall");

endmodule
